// ===== sv/wslm_pkg.sv =====
// ============================================================================
// Windowed sound level meter package
// Sequencer states and fixed constants of the level-to-dB conversion.
// ============================================================================
package wslm_pkg;

    // 20*log10(2) in Q16, rounded.
    localparam int DB_PER_LOG2_Q16 = 394566;

    // Number of fraction bits produced by the log2 squaring loop.
    localparam int LOG_FRAC_BITS = 16;

    // Levels carry 8 fraction bits; log2 of the level is lowered by this many units.
    localparam int LEVEL_FRAC_BITS = 8;

    // Reset value of the dB offset register, in 1/256 dB.
    localparam logic signed [15:0] DB_OFFSET_RESET = 16'sd17947;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_SQUARE,
        ST_SCALE,
        ST_ROUND,
        ST_DONE
    } wslm_state_t;

endpackage

// ===== sv/windowed_sound_level_meter.sv =====
// ============================================================================
// Windowed sound level meter
// Collects converter samples into a window and, on a close request, reports
// mean and peak AC level in 1/256 dB, the peak-to-peak code and the count.
// ============================================================================
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_ready   | operation, sample
//  output  | out_valid / out_ready | mean_db, peak_db, peak_to_peak, sample_total
//  config  | cfg_we                | cfg_wdata (db_offset, no wait, no read-back)
//
// A sample request is folded into the window as soon as it is taken.
// A close request keeps in_ready low until its result is loaded. The
// bit-serial divider that forms the mean is DIV_BITS = SAMPLE_BITS + count
// width + 8 bits long; each of the two levels is then normalized by shifts
// and takes sixteen squaring steps on the one shared 32 x 32 multiplier.
// An empty window skips the divider, and a zero level ends its pass
// straight from normalization.
// Reset is asynchronous and clears the window and sets db_offset to 17947.
// The result register lets sample requests be taken while a result waits;
// a second close waits in its last state until the earlier result is taken.
//
module windowed_sound_level_meter #(
    parameter int MAX_WINDOW_SAMPLES = 65535,
    parameter int SAMPLE_BITS        = 12
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [15:0]        sample,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] mean_db,
    output logic signed [15:0] peak_db,
    output logic [11:0]        peak_to_peak,
    output logic [15:0]        sample_total,

    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    // Width of the sample counter, wide enough to hold the window limit itself.
    localparam int CW       = $clog2(MAX_WINDOW_SAMPLES + 1);
    // The level sum needs the sample width plus the counter width.
    localparam int SUMW     = SAMPLE_BITS + CW;
    // The divider works on the level sum scaled by 256.
    localparam int DW       = SUMW + wslm_pkg::LEVEL_FRAC_BITS;
    localparam int DCW      = (DW > 1) ? $clog2(DW) : 1;
    localparam logic [15:0] CODE_MAX16 = 16'((1 << SAMPLE_BITS) - 1);
    localparam logic [SAMPLE_BITS-1:0] CODE_MAX = SAMPLE_BITS'((1 << SAMPLE_BITS) - 1);
    localparam logic [SAMPLE_BITS:0]   CODE_MAX_X = (SAMPLE_BITS + 1)'((1 << SAMPLE_BITS) - 1);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_WINDOW_SAMPLES);

    // Control state.
    wslm_pkg::wslm_state_t state_reg, state_next;
    logic                  pass_peak_reg, pass_peak_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [15:0]    db_offset_reg;

    // Window state.
    logic [SUMW-1:0]        level_sum_reg, level_sum_next;
    logic [SAMPLE_BITS-1:0] level_peak_reg, level_peak_next;
    logic [SAMPLE_BITS-1:0] code_max_reg, code_max_next;
    logic [SAMPLE_BITS-1:0] code_min_reg, code_min_next;
    logic [CW-1:0]          count_reg, count_next;

    // Working registers of the divider and the log unit.
    logic [DW-1:0]          div_quo_reg, div_quo_next;
    logic [CW-1:0]          div_rem_reg, div_rem_next;
    logic [DCW-1:0]         div_cnt_reg, div_cnt_next;
    logic [30:0]            m_reg, m_next;
    logic [4:0]             e_reg, e_next;
    logic [15:0]            frac_reg, frac_next;
    logic [3:0]             sq_cnt_reg, sq_cnt_next;
    logic signed [47:0]     prod_reg, prod_next;

    // Result registers.
    logic signed [15:0]     mean_db_reg, mean_db_next;
    logic signed [15:0]     peak_db_reg, peak_db_next;
    logic signed [15:0]     mean_hold_reg, mean_hold_next;
    logic [11:0]            p2p_reg, p2p_next;
    logic [15:0]            total_reg, total_next;

    // Combinational helpers.
    logic                   in_fire;
    logic                   sample_ok;
    logic [SAMPLE_BITS-1:0] code;
    logic [SAMPLE_BITS:0]   code_x2;
    logic [SAMPLE_BITS-1:0] level;
    logic [CW:0]            div_trial;
    logic                   div_bit;
    logic                   div_last;
    logic signed [31:0]     mul_a, mul_b;
    logic signed [63:0]     mul_prod;
    logic [30:0]            sq_m;
    logic signed [22:0]     lg;
    logic signed [47:0]     rounded;
    logic signed [24:0]     db_sum;
    logic signed [15:0]     db_sat;
    logic                   pass_end;
    logic signed [15:0]     pass_db;
    logic                   out_load;

    assign in_ready  = (state_reg == wslm_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = (state_reg == wslm_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // Sample conditioning: the level is the distance of the doubled code from
    // full scale, in half-codes.
    assign sample_ok = (sample <= CODE_MAX16) && (count_reg < COUNT_LIMIT);
    assign code      = sample[SAMPLE_BITS-1:0];
    assign code_x2   = {code, 1'b0};
    assign level     = (code_x2 >= CODE_MAX_X) ? SAMPLE_BITS'(code_x2 - CODE_MAX_X)
                                               : SAMPLE_BITS'(CODE_MAX_X - code_x2);

    // One restoring division step per cycle.
    assign div_trial = {div_rem_reg, div_quo_reg[DW-1]};
    assign div_bit   = (div_trial >= {1'b0, count_reg});
    assign div_last  = (div_cnt_reg == DCW'(DW - 1));

    // The shared multiplier squares the mantissa, then scales log2 into dB.
    assign lg = $signed({2'b00, e_reg, frac_reg})
              - 23'sd524288;
    always_comb
    begin
        if (state_reg == wslm_pkg::ST_SCALE)
        begin
            mul_a = 32'(lg);
            mul_b = 32'(wslm_pkg::DB_PER_LOG2_Q16);
        end
        else
        begin
            mul_a = $signed({1'b0, m_reg});
            mul_b = $signed({1'b0, m_reg});
        end
    end
    assign mul_prod = mul_a * mul_b;
    assign sq_m     = mul_prod[61] ? mul_prod[61:31] : mul_prod[60:30];

    // Round to 1/256 dB, add the offset and saturate.
    assign rounded = prod_reg + 48'sd8388608;
    assign db_sum  = 25'($signed(rounded[47:24])) + 25'(db_offset_reg);
    always_comb
    begin
        if (db_sum > 25'sd32767)
            db_sat = 16'sd32767;
        else if (db_sum < -25'sd32768)
            db_sat = -16'sd32768;
        else
            db_sat = db_sum[15:0];
    end

    // A level pass ends with a zero level straight from normalization, or
    // after rounding.
    assign pass_end = ((state_reg == wslm_pkg::ST_NORM) && (m_reg == 31'd0))
                   || (state_reg == wslm_pkg::ST_ROUND);
    assign pass_db  = (state_reg == wslm_pkg::ST_ROUND) ? db_sat : 16'sd0;

    // Next state.
    always_comb
    begin
        state_next     = state_reg;
        pass_peak_next = pass_peak_reg;
        unique case (state_reg)
            wslm_pkg::ST_IDLE:
            begin
                if (in_fire && operation)
                begin
                    pass_peak_next = 1'b0;
                    state_next = (count_reg == '0) ? wslm_pkg::ST_NORM : wslm_pkg::ST_DIV;
                end
            end
            wslm_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = wslm_pkg::ST_NORM;
            end
            wslm_pkg::ST_NORM:
            begin
                if (m_reg == 31'd0)
                begin
                    pass_peak_next = 1'b1;
                    state_next = pass_peak_reg ? wslm_pkg::ST_DONE : wslm_pkg::ST_NORM;
                end
                else if (m_reg[30])
                    state_next = wslm_pkg::ST_SQUARE;
            end
            wslm_pkg::ST_SQUARE:
            begin
                if (sq_cnt_reg == 4'(wslm_pkg::LOG_FRAC_BITS - 1))
                    state_next = wslm_pkg::ST_SCALE;
            end
            wslm_pkg::ST_SCALE:
                state_next = wslm_pkg::ST_ROUND;
            wslm_pkg::ST_ROUND:
            begin
                pass_peak_next = 1'b1;
                state_next = pass_peak_reg ? wslm_pkg::ST_DONE : wslm_pkg::ST_NORM;
            end
            wslm_pkg::ST_DONE:
            begin
                if (out_load)
                    state_next = wslm_pkg::ST_IDLE;
            end
            default:
                state_next = wslm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        level_sum_next  = level_sum_reg;
        level_peak_next = level_peak_reg;
        code_max_next   = code_max_reg;
        code_min_next   = code_min_reg;
        count_next      = count_reg;
        div_quo_next    = div_quo_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        m_next          = m_reg;
        e_next          = e_reg;
        frac_next       = frac_reg;
        sq_cnt_next     = sq_cnt_reg;
        prod_next       = prod_reg;
        mean_hold_next  = mean_hold_reg;
        mean_db_next    = mean_db_reg;
        peak_db_next    = peak_db_reg;
        p2p_next        = p2p_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (in_fire && !operation && sample_ok)
        begin
            if (code > code_max_reg)
                code_max_next = code;
            if (code < code_min_reg)
                code_min_next = code;
            if (level > level_peak_reg)
                level_peak_next = level;
            level_sum_next = level_sum_reg + SUMW'(level);
            count_next     = count_reg + 1'b1;
        end

        if (in_fire && operation)
        begin
            div_quo_next = {level_sum_reg, 8'd0};
            div_rem_next = '0;
            div_cnt_next = '0;
            m_next       = 31'd0;
            e_next       = 5'd30;
        end

        if (state_reg == wslm_pkg::ST_DIV)
        begin
            div_quo_next = {div_quo_reg[DW-2:0], div_bit};
            div_rem_next = div_bit ? CW'(div_trial - {1'b0, count_reg}) : CW'(div_trial);
            div_cnt_next = div_cnt_reg + 1'b1;
            if (div_last)
            begin
                m_next = 31'({div_quo_reg[DW-2:0], div_bit});
                e_next = 5'd30;
            end
        end

        if ((state_reg == wslm_pkg::ST_NORM) && (m_reg != 31'd0))
        begin
            if (m_reg[30])
            begin
                sq_cnt_next = 4'd0;
                frac_next   = 16'd0;
            end
            else
            begin
                m_next = {m_reg[29:0], 1'b0};
                e_next = e_reg - 1'b1;
            end
        end

        if (state_reg == wslm_pkg::ST_SQUARE)
        begin
            m_next      = sq_m;
            frac_next   = {frac_reg[14:0], mul_prod[61]};
            sq_cnt_next = sq_cnt_reg + 1'b1;
        end

        if (state_reg == wslm_pkg::ST_SCALE)
            prod_next = mul_prod[47:0];

        if (pass_end)
        begin
            if (pass_peak_reg)
                peak_db_next = pass_db;
            else
            begin
                mean_hold_next = pass_db;
                m_next = 31'({level_peak_reg, 8'd0});
                e_next = 5'd30;
            end
        end

        if (out_load)
        begin
            mean_db_next   = mean_hold_reg;
            p2p_next       = (count_reg != '0) ? 12'(code_max_reg - code_min_reg) : 12'd0;
            total_next     = 16'(count_reg);
            out_valid_next = 1'b1;
            level_sum_next  = '0;
            level_peak_next = '0;
            code_max_next   = '0;
            code_min_next   = CODE_MAX;
            count_next      = '0;
        end
    end

    // The peak result register is loaded before the output register frees,
    // so the shown peak value is held apart in its own output copy.
    logic signed [15:0] peak_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wslm_pkg::ST_IDLE;
            pass_peak_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            db_offset_reg  <= wslm_pkg::DB_OFFSET_RESET;
            level_sum_reg  <= '0;
            level_peak_reg <= '0;
            code_max_reg   <= '0;
            code_min_reg   <= CODE_MAX;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_peak_reg  <= pass_peak_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                db_offset_reg <= $signed(cfg_wdata);
            level_sum_reg  <= level_sum_next;
            level_peak_reg <= level_peak_next;
            code_max_reg   <= code_max_next;
            code_min_reg   <= code_min_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_quo_reg   <= div_quo_next;
        div_rem_reg   <= div_rem_next;
        div_cnt_reg   <= div_cnt_next;
        m_reg         <= m_next;
        e_reg         <= e_next;
        frac_reg      <= frac_next;
        sq_cnt_reg    <= sq_cnt_next;
        prod_reg      <= prod_next;
        mean_hold_reg <= mean_hold_next;
        mean_db_reg   <= mean_db_next;
        peak_db_reg   <= peak_db_next;
        p2p_reg       <= p2p_next;
        total_reg     <= total_next;
        if (out_load)
            peak_out_reg <= peak_db_reg;
    end

    assign out_valid    = out_valid_reg;
    assign mean_db      = mean_db_reg;
    assign peak_db      = peak_out_reg;
    assign peak_to_peak = p2p_reg;
    assign sample_total = total_reg;

`ifndef SYNTHESIS
    // The window never holds more samples than its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("sample count beyond window limit");

    // A close request makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation) |=> !in_ready)
        else $error("close request did not start the sequencer");

    // Loading a result clears the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (count_reg == '0) && (level_sum_reg == '0) && out_valid)
        else $error("window not cleared after a result");

    // The squaring loop only ever sees a normalized mantissa.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wslm_pkg::ST_SQUARE) |-> m_reg[30])
        else $error("mantissa not normalized in squaring loop");
`endif

endmodule

// ===== tb/windowed_sound_level_meter_tb.sv =====
// ============================================================================
// Windowed sound level meter testbench
// Sends sample and close requests over the valid/ready input channel with
// random gaps on both sides. It keeps its own copy of the window state and
// the dB offset, predicts every report, and checks each report field by
// field against the oldest prediction.
// ============================================================================
module windowed_sound_level_meter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes of the input request.
    localparam logic OP_ADD_SAMPLE   = 1'b0;
    localparam logic OP_CLOSE_WINDOW = 1'b1;

    // Largest converter code and the sample limit of one window.
    localparam int unsigned FULL_SCALE_CODE = 4095;
    localparam int unsigned WINDOW_LIMIT    = 65535;

    // 20*log10(2) in Q16, used to turn log2 into dB.
    localparam longint DB_PER_OCTAVE_Q16 = 394566;

    // Idle margin that covers the time a close keeps the block busy.
    localparam int SETTLE_CYCLES = 160;

    // Least number of requests sent in each random phase.
    localparam int PHASE_REQUESTS = 330;

    // Number of random in-range samples in the long window.
    localparam int LONG_WINDOW_SAMPLES = 100;

    typedef struct packed {
        logic signed [15:0] mean_db;
        logic signed [15:0] peak_db;
        logic [11:0]        peak_to_peak;
        logic [15:0]        sample_total;
    } meter_report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = OP_ADD_SAMPLE;
    logic [15:0]        sample = 16'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] mean_db;
    logic signed [15:0] peak_db;
    logic [11:0]        peak_to_peak;
    logic [15:0]        sample_total;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = 16'd0;

    // Idle rates in percent for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures = 0;

    // Predicted reports, oldest first.
    meter_report_t expected_reports[$];

    // Our copy of the window state and the offset register.
    longint unsigned    win_level_sum;
    int unsigned        win_level_peak;
    int unsigned        win_code_max;
    int unsigned        win_code_min;
    int unsigned        win_count;
    logic signed [15:0] meter_offset;

    windowed_sound_level_meter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_db      (mean_db),
        .peak_db      (peak_db),
        .peak_to_peak (peak_to_peak),
        .sample_total (sample_total),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Converts a level with 8 fraction bits into 1/256 dB plus the offset.
    // The fraction of log2 comes from repeated squaring of the Q30 mantissa,
    // one bit per squaring, most significant bit first.
    function automatic logic signed [15:0] level_in_db(input longint unsigned level);
        int unsigned     lead;
        int unsigned     frac;
        longint unsigned mant;
        longint          log2_q16;
        longint          db;
        if (level == 0)
            return 16'sd0;
        lead = 0;
        while (lead < 29 && (level >> (lead + 1)) != 0)
            lead++;
        mant = level << (30 - lead);
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= 64'h8000_0000)
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        log2_q16 = longint'(lead) * 65536 + longint'(frac) - 8 * 65536;
        // Round to the nearest 1/256 dB; the shift floors negative values too.
        db = (log2_q16 * DB_PER_OCTAVE_Q16 + (64'sd1 <<< 23)) >>> 24;
        db = db + longint'(meter_offset);
        if (db > 32767)
            db = 32767;
        if (db < -32768)
            db = -32768;
        return db[15:0];
    endfunction

    // Sends one request and folds it into the predicted window once the
    // block has taken it. Valid stays high after acceptance so that a
    // back-to-back request needs only one assignment in its time step.
    task automatic send_request(input logic op, input logic [15:0] smp);
        int unsigned   lvl;
        longint unsigned mean_level;
        meter_report_t rep;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample    <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        if (op == OP_ADD_SAMPLE)
        begin
            // Codes above full scale and samples past a full window are dropped.
            if (smp <= FULL_SCALE_CODE && win_count < WINDOW_LIMIT)
            begin
                if (smp > win_code_max)
                    win_code_max = smp;
                if (smp < win_code_min)
                    win_code_min = smp;
                lvl = (2 * smp >= FULL_SCALE_CODE) ? 2 * smp - FULL_SCALE_CODE
                                                   : FULL_SCALE_CODE - 2 * smp;
                win_level_sum = win_level_sum + lvl;
                if (lvl > win_level_peak)
                    win_level_peak = lvl;
                win_count++;
            end
        end
        else
        begin
            // An empty window reports zero everywhere.
            mean_level       = 0;
            rep.peak_to_peak = 12'd0;
            if (win_count != 0)
            begin
                mean_level       = (win_level_sum << 8) / win_count;
                rep.peak_to_peak = 12'(win_code_max - win_code_min);
            end
            rep.mean_db      = level_in_db(mean_level);
            rep.peak_db      = level_in_db(longint'(win_level_peak) << 8);
            rep.sample_total = 16'(win_count);
            expected_reports.push_back(rep);
            win_level_sum  = 0;
            win_level_peak = 0;
            win_code_max   = 0;
            win_code_min   = FULL_SCALE_CODE;
            win_count      = 0;
        end
    endtask

    // Lowers valid and holds off until every predicted report has arrived.
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // The offset register is only written while the block is idle.
    task automatic write_db_offset(input logic [15:0] value);
        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        meter_offset = value;
    endtask

    // Draws a sample: mostly in range with the extremes favored, sometimes
    // above full scale, sometimes any 16-bit value.
    function automatic logic [15:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return 16'($urandom);
            1:       return 16'd0;
            2:       return 16'(FULL_SCALE_CODE);
            3:       return 16'($urandom_range(FULL_SCALE_CODE + 1, 65535));
            default: return 16'($urandom_range(0, FULL_SCALE_CODE));
        endcase
    endfunction

    // Empty window, both code extremes, ignored out-of-range codes and the
    // smallest nonzero level, all at the reset offset.
    task automatic test_directed_cases();
        send_request(OP_CLOSE_WINDOW, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd4095);
        send_request(OP_CLOSE_WINDOW, 16'hFFFF);
        send_request(OP_ADD_SAMPLE, 16'd2047);
        send_request(OP_ADD_SAMPLE, 16'd2048);
        send_request(OP_ADD_SAMPLE, 16'hFFFF);
        send_request(OP_ADD_SAMPLE, 16'd4096);
        send_request(OP_ADD_SAMPLE, 16'h8000);
        send_request(OP_CLOSE_WINDOW, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd1);
        send_request(OP_ADD_SAMPLE, 16'd4094);
        send_request(OP_ADD_SAMPLE, 16'd2047);
        send_request(OP_CLOSE_WINDOW, 16'h5555);
        send_request(OP_ADD_SAMPLE, 16'd4095);
        send_request(OP_CLOSE_WINDOW, 16'hAAAA);
    endtask

    // Drives both ends of the offset range; at the top end the sum saturates.
    task automatic test_offset_extremes();
        write_db_offset(16'h8000);
        send_request(OP_ADD_SAMPLE, 16'd2047);
        send_request(OP_ADD_SAMPLE, 16'd2048);
        send_request(OP_CLOSE_WINDOW, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd0);
        send_request(OP_CLOSE_WINDOW, 16'd0);
        write_db_offset(16'h7FFF);
        send_request(OP_ADD_SAMPLE, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd4095);
        send_request(OP_CLOSE_WINDOW, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd2047);
        send_request(OP_CLOSE_WINDOW, 16'd0);
        write_db_offset(16'h0000);
        send_request(OP_ADD_SAMPLE, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd2047);
        send_request(OP_CLOSE_WINDOW, 16'd0);
    endtask

    // Random windows of mostly short length, with a few empty closes and a
    // few long windows. Halfway through, the sender stops until all reports
    // are back.
    task automatic test_random_windows(input int sender_pct, input int receiver_pct);
        int sent;
        int window_len;
        int unsigned kind;
        bit paused;
        write_db_offset(16'($urandom));
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < PHASE_REQUESTS)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                window_len = 0;
            else if (kind == 9)
                window_len = $urandom_range(20, 60);
            else
                window_len = $urandom_range(1, 12);
            for (int i = 0; i < window_len; i++)
                send_request(OP_ADD_SAMPLE, random_sample());
            send_request(OP_CLOSE_WINDOW, 16'($urandom));
            sent = sent + window_len + 1;
            if (!paused && sent >= PHASE_REQUESTS / 2)
            begin
                wait_for_reports();
                paused = 1'b1;
            end
        end
    endtask

    // One long window of in-range samples and one out-of-range code, sent
    // back to back. A short window afterwards shows the clear.
    task automatic test_long_window();
        write_db_offset(16'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < LONG_WINDOW_SAMPLES; i++)
            send_request(OP_ADD_SAMPLE, 16'($urandom_range(0, FULL_SCALE_CODE)));
        send_request(OP_ADD_SAMPLE, 16'hFFFF);
        send_request(OP_ADD_SAMPLE, 16'd4095);
        send_request(OP_ADD_SAMPLE, 16'd2047);
        send_request(OP_CLOSE_WINDOW, 16'd0);
        send_request(OP_ADD_SAMPLE, 16'd3000);
        send_request(OP_CLOSE_WINDOW, 16'd0);
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
            failures++;
        end
    endtask

    // Every report the block hands over is checked against the oldest
    // prediction. Values are read at the edge, before any update of it.
    always @(posedge clk)
    begin : report_checker
        meter_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: report with none expected, actual %h %h %h %h", $time,
                         mean_db, peak_db, peak_to_peak, sample_total);
                failures++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("mean_db", want.mean_db, mean_db);
                check_field("peak_db", want.peak_db, peak_db);
                check_field("peak_to_peak", {4'd0, want.peak_to_peak}, {4'd0, peak_to_peak});
                check_field("sample_total", want.sample_total, sample_total);
            end
        end
    end

    // The whole run fits in well under this time; reaching it means a hang.
    initial
    begin
        #20_000_000;
        $display("[windowed_sound_level_meter] ERROR");
        $finish;
    end

    initial
    begin
        meter_offset   = wslm_pkg::DB_OFFSET_RESET;
        win_level_sum  = 0;
        win_level_peak = 0;
        win_code_max   = 0;
        win_code_min   = FULL_SCALE_CODE;
        win_count      = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_offset_extremes();
        test_random_windows(30, 63);
        test_random_windows(63, 30);
        test_random_windows(0, 0);
        test_long_window();

        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && expected_reports.size() == 0)
            $display("[windowed_sound_level_meter] OK");
        else
            $display("[windowed_sound_level_meter] ERROR");
        $finish;
    end

endmodule
